>>> rtl/core/mbfs_pkg.sv
package mbfs_pkg;

  localparam int MaxFlagBytes = 4;
  localparam int IdxW         = $clog2(MaxFlagBytes);
  localparam int LenW         = $clog2(MaxFlagBytes + 1);
  localparam int PatW         = 32;
  localparam int QueueDepth   = 4;
  localparam int QPtrW        = $clog2(QueueDepth);
  localparam int QCntW        = $clog2(QueueDepth + 1);

  typedef enum logic [2:0] {
    CfgStartPattern = 3'd0,
    CfgStartLength  = 3'd1,
    CfgEndPattern   = 3'd2,
    CfgEndLength    = 3'd3,
    CfgEscapeByte   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StLoop,
    StStuff,
    StEnd
  } state_e;

  // One queued payload beat, tagged by the front with whether it opens a frame.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       opens;
  } beat_t;

  typedef struct packed {
    logic [PatW-1:0] start_pattern;
    logic [LenW-1:0] start_len;
    logic [PatW-1:0] end_pattern;
    logic [LenW-1:0] end_len;
    logic [7:0]      escape;
  } cfg_t;

  // A length of zero acts as one; lengths above the window size are clipped.
  function automatic logic [LenW-1:0] eff_len(input logic [2:0] raw);
    logic [LenW-1:0] len;
    if (raw == 3'd0) begin
      len = LenW'(1);
    end else if (int'(raw) > MaxFlagBytes) begin
      len = LenW'(MaxFlagBytes);
    end else begin
      len = LenW'(raw);
    end
    return len;
  endfunction

  // Pattern bytes beyond the register read as zero.
  function automatic logic [7:0] pat_byte(input logic [PatW-1:0] pat,
                                          input logic [IdxW-1:0] k);
    logic [MaxFlagBytes*8+PatW-1:0] ext;
    ext = {(MaxFlagBytes*8)'(0), pat};
    return ext[8*k +: 8];
  endfunction

  // True when the window still has a decision to make.
  function automatic logic more_work(input logic [LenW-1:0] fill,
                                     input logic            last,
                                     input logic [LenW-1:0] need);
    return (fill != '0) && (last || (fill >= need));
  endfunction

endpackage

>>> rtl/core/multi_byte_flag_byte_stuffer_core.sv
// Accepted beats go into the queue; the back end pops one into its lookahead window
// only while idle, and each result byte is registered before it appears on m_axis.
// The output engine emits one result byte per cycle while m_axis is not stalled and
// takes no new beat before it is done with the last; a four-entry queue decouples
// input from engine. Reset: configuration returns to its defaults, no frame is open,
// the window and the queue are empty.
module multi_byte_flag_byte_stuffer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,   // frame_last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [0:0]  m_axis_tuser,   // [0] frame_done
  output logic        m_axis_tlast,   // run_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  mbfs_pkg::cfg_t  cfg_q;
  logic            q_valid;
  logic            q_pop;
  mbfs_pkg::beat_t q_beat;
  logic            done;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_pattern <= mbfs_pkg::PatW'(2);
      cfg_q.start_len     <= mbfs_pkg::LenW'(1);
      cfg_q.end_pattern   <= mbfs_pkg::PatW'(3);
      cfg_q.end_len       <= mbfs_pkg::LenW'(1);
      cfg_q.escape        <= 8'd27;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (mbfs_pkg::cfg_idx_e'(cfg_index_i))
        mbfs_pkg::CfgStartPattern: cfg_q.start_pattern <= cfg_data_i;
        mbfs_pkg::CfgStartLength:  cfg_q.start_len <= mbfs_pkg::eff_len(cfg_data_i[2:0]);
        mbfs_pkg::CfgEndPattern:   cfg_q.end_pattern <= cfg_data_i;
        mbfs_pkg::CfgEndLength:    cfg_q.end_len <= mbfs_pkg::eff_len(cfg_data_i[2:0]);
        mbfs_pkg::CfgEscapeByte:   cfg_q.escape <= cfg_data_i[7:0];
        default: begin
          cfg_q <= cfg_q;
        end
      endcase
    end
  end

  mbfs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_last_i  (s_axis_tlast),
    .q_valid_o  (q_valid),
    .q_pop_i    (q_pop),
    .q_beat_o   (q_beat)
  );

  mbfs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_pop_o     (q_pop),
    .q_beat_i    (q_beat),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_done_o  (done),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tuser = done;

endmodule

>>> rtl/core/mbfs_front.sv
module mbfs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_data_i,
  input  logic          in_last_i,
  output logic          q_valid_o,
  input  logic          q_pop_i,
  output mbfs_pkg::beat_t q_beat_o
);

  mbfs_pkg::beat_t                 mem_q [mbfs_pkg::QueueDepth];
  logic [mbfs_pkg::QPtrW-1:0]      wr_ptr_q, wr_ptr_d;
  logic [mbfs_pkg::QPtrW-1:0]      rd_ptr_q, rd_ptr_d;
  logic [mbfs_pkg::QCntW-1:0]      count_q, count_d;
  logic                            opens_q, opens_d;
  logic                            push;
  logic                            pop;
  mbfs_pkg::beat_t                 wr_beat;

  assign in_ready_o = (count_q != mbfs_pkg::QCntW'(mbfs_pkg::QueueDepth));
  assign q_valid_o  = (count_q != '0);
  assign q_beat_o   = mem_q[rd_ptr_q];

  assign push = in_valid_i && in_ready_o;
  assign pop  = q_pop_i && q_valid_o;

  // The first beat after reset, or after a last beat, opens a new frame.
  always_comb begin
    wr_beat.data  = in_data_i;
    wr_beat.last  = in_last_i;
    wr_beat.opens = opens_q;
    opens_d  = push ? in_last_i : opens_q;
    wr_ptr_d = push ? wr_ptr_q + mbfs_pkg::QPtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + mbfs_pkg::QPtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + mbfs_pkg::QCntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - mbfs_pkg::QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
      opens_q  <= 1'b1;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
      opens_q  <= opens_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_beat;
    end
  end

endmodule

>>> rtl/core/mbfs_back.sv
module mbfs_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mbfs_pkg::cfg_t  cfg_i,
  input  logic            q_valid_i,
  output logic            q_pop_o,
  input  mbfs_pkg::beat_t q_beat_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [7:0]      out_byte_o,
  output logic            out_done_o,
  output logic            out_last_o
);

  mbfs_pkg::state_e             state_q, state_d;
  logic [7:0]                   win_q [mbfs_pkg::MaxFlagBytes];
  logic [7:0]                   win_d [mbfs_pkg::MaxFlagBytes];
  logic [mbfs_pkg::LenW-1:0]    fill_q, fill_d;
  logic [mbfs_pkg::IdxW-1:0]    k_q, k_d;
  logic                         sel_end_q, sel_end_d;
  logic                         cur_last_q, cur_last_d;
  logic                         out_valid_q;
  logic [7:0]                   out_byte_q;
  logic                         out_done_q;
  logic                         out_last_q;

  logic                         fire;
  logic                         emit;
  logic [7:0]                   emit_byte;
  logic                         emit_done;
  logic                         emit_last;
  logic                         drop_en;
  logic [mbfs_pkg::LenW-1:0]    drop_n;
  logic [mbfs_pkg::LenW-1:0]    need;
  logic [mbfs_pkg::LenW-1:0]    fill_inc;
  logic [mbfs_pkg::LenW-1:0]    fill_after;
  logic [mbfs_pkg::PatW-1:0]    stuff_pat;
  logic [mbfs_pkg::LenW-1:0]    stuff_len;
  logic [mbfs_pkg::LenW-1:0]    stage_len;
  logic                         stage_final;
  logic                         next_more;
  logic                         start_hit;
  logic                         end_hit;
  logic [mbfs_pkg::MaxFlagBytes-1:0] start_ok;
  logic [mbfs_pkg::MaxFlagBytes-1:0] end_ok;
  logic [mbfs_pkg::LenW:0]      src_idx;

  // The output register may load when empty or when its beat leaves now.
  assign fire      = !out_valid_q || out_ready_i;
  assign need      = (cfg_i.start_len > cfg_i.end_len) ? cfg_i.start_len : cfg_i.end_len;
  assign fill_inc  = fill_q + mbfs_pkg::LenW'(1);
  assign stuff_pat = sel_end_q ? cfg_i.end_pattern : cfg_i.start_pattern;
  assign stuff_len = sel_end_q ? cfg_i.end_len : cfg_i.start_len;
  assign q_pop_o   = (state_q == mbfs_pkg::StIdle) && q_valid_i;

  // Head compare against both patterns; bytes past the pattern length are don't-care.
  always_comb begin
    for (int k = 0; k < mbfs_pkg::MaxFlagBytes; k++) begin
      start_ok[k] = (mbfs_pkg::LenW'(k) >= cfg_i.start_len) ||
                    (win_q[k] == mbfs_pkg::pat_byte(cfg_i.start_pattern,
                                                    mbfs_pkg::IdxW'(k)));
      end_ok[k]   = (mbfs_pkg::LenW'(k) >= cfg_i.end_len) ||
                    (win_q[k] == mbfs_pkg::pat_byte(cfg_i.end_pattern,
                                                    mbfs_pkg::IdxW'(k)));
    end
    start_hit = (fill_q >= cfg_i.start_len) && (&start_ok);
    end_hit   = (fill_q >= cfg_i.end_len) && (&end_ok);
  end

  always_comb begin
    case (state_q)
      mbfs_pkg::StStart: stage_len = cfg_i.start_len;
      mbfs_pkg::StStuff: stage_len = stuff_len;
      mbfs_pkg::StEnd:   stage_len = cfg_i.end_len;
      default:           stage_len = mbfs_pkg::LenW'(1);
    endcase
    stage_final = (k_q == mbfs_pkg::IdxW'(stage_len - mbfs_pkg::LenW'(1)));

    case (state_q)
      mbfs_pkg::StLoop:  fill_after = fill_q - mbfs_pkg::LenW'(1);
      mbfs_pkg::StStuff: fill_after = fill_q - stuff_len;
      default:           fill_after = fill_q;
    endcase
    next_more = mbfs_pkg::more_work(fill_after, cur_last_q, need);
  end

  // Output and datapath control.
  always_comb begin
    emit       = 1'b0;
    emit_byte  = '0;
    emit_done  = 1'b0;
    emit_last  = 1'b0;
    drop_en    = 1'b0;
    drop_n     = mbfs_pkg::LenW'(1);
    fill_d     = fill_q;
    k_d        = k_q;
    sel_end_d  = sel_end_q;
    cur_last_d = cur_last_q;

    case (state_q)
      mbfs_pkg::StIdle: begin
        if (q_valid_i) begin
          fill_d     = fill_inc;
          cur_last_d = q_beat_i.last;
          k_d        = '0;
        end
      end
      mbfs_pkg::StStart: begin
        emit      = fire;
        emit_byte = mbfs_pkg::pat_byte(cfg_i.start_pattern, k_q);
        emit_last = stage_final && !next_more && !cur_last_q;
        if (fire) begin
          k_d = stage_final ? '0 : k_q + mbfs_pkg::IdxW'(1);
        end
      end
      mbfs_pkg::StLoop: begin
        emit = fire;
        if (start_hit || end_hit) begin
          emit_byte = cfg_i.escape;
          if (fire) begin
            sel_end_d = !start_hit;
            k_d       = '0;
          end
        end else begin
          emit_byte = win_q[0];
          emit_last = !next_more && !cur_last_q;
          if (fire) begin
            drop_en = 1'b1;
            fill_d  = fill_after;
          end
        end
      end
      mbfs_pkg::StStuff: begin
        emit      = fire;
        emit_byte = mbfs_pkg::pat_byte(stuff_pat, k_q);
        emit_last = stage_final && !next_more && !cur_last_q;
        drop_n    = stuff_len;
        if (fire) begin
          if (stage_final) begin
            drop_en = 1'b1;
            fill_d  = fill_after;
            k_d     = '0;
          end else begin
            k_d = k_q + mbfs_pkg::IdxW'(1);
          end
        end
      end
      mbfs_pkg::StEnd: begin
        emit      = fire;
        emit_byte = mbfs_pkg::pat_byte(cfg_i.end_pattern, k_q);
        emit_done = stage_final;
        emit_last = stage_final;
        if (fire) begin
          if (stage_final) begin
            fill_d = '0;
            k_d    = '0;
          end else begin
            k_d = k_q + mbfs_pkg::IdxW'(1);
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Window update: insert at the fill point, or shift the head out.
  always_comb begin
    src_idx = '0;
    win_d   = win_q;
    if (q_pop_o) begin
      win_d[fill_q[mbfs_pkg::IdxW-1:0]] = q_beat_i.data;
    end
    if (drop_en) begin
      for (int k = 0; k < mbfs_pkg::MaxFlagBytes; k++) begin
        src_idx = (mbfs_pkg::LenW+1)'(k) + {1'b0, drop_n};
        if (src_idx < (mbfs_pkg::LenW+1)'(mbfs_pkg::MaxFlagBytes)) begin
          win_d[k] = win_q[src_idx[mbfs_pkg::IdxW-1:0]];
        end
      end
    end
  end

  // Next state.
  always_comb begin
    mbfs_pkg::state_e after_st;
    after_st = next_more ? mbfs_pkg::StLoop
             : (cur_last_q ? mbfs_pkg::StEnd : mbfs_pkg::StIdle);
    state_d  = state_q;
    case (state_q)
      mbfs_pkg::StIdle: begin
        if (q_valid_i) begin
          if (q_beat_i.opens) begin
            state_d = mbfs_pkg::StStart;
          end else if (mbfs_pkg::more_work(fill_inc, q_beat_i.last, need)) begin
            state_d = mbfs_pkg::StLoop;
          end
        end
      end
      mbfs_pkg::StStart: begin
        if (fire && stage_final) begin
          state_d = after_st;
        end
      end
      mbfs_pkg::StLoop: begin
        if (fire) begin
          state_d = (start_hit || end_hit) ? mbfs_pkg::StStuff : after_st;
        end
      end
      mbfs_pkg::StStuff: begin
        if (fire && stage_final) begin
          state_d = after_st;
        end
      end
      mbfs_pkg::StEnd: begin
        if (fire && stage_final) begin
          state_d = mbfs_pkg::StIdle;
        end
      end
      default: begin
        state_d = mbfs_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= mbfs_pkg::StIdle;
      fill_q      <= '0;
      k_q         <= '0;
      sel_end_q   <= 1'b0;
      cur_last_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      fill_q     <= fill_d;
      k_q        <= k_d;
      sel_end_q  <= sel_end_d;
      cur_last_q <= cur_last_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    win_q <= win_d;
    if (emit) begin
      out_byte_q <= emit_byte;
      out_done_q <= emit_done;
      out_last_q <= emit_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_done_o  = out_done_q;
  assign out_last_o  = out_last_q;

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= mbfs_pkg::LenW'(mbfs_pkg::MaxFlagBytes))
    else $error("window fill exceeds window size");

  a_start_one_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbfs_pkg::StStart) |-> (fill_q == mbfs_pkg::LenW'(1)))
    else $error("start flag sent with a stale window");

  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == mbfs_pkg::StEnd) |-> (fill_q == '0))
    else $error("end flag sent before the window was flushed");

  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_done_q) |-> out_last_q)
    else $error("frame end beat not marked as last of its run");

  a_stuff_after_escape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == mbfs_pkg::StStuff) |->
      ($past(state_q) == mbfs_pkg::StLoop) && $past(out_ready_i || !out_valid_q))
    else $error("stuffed pattern without a preceding escape");

endmodule
